// ===== design/iaidf_pkg.sv =====
// Package for the indexed array insert/delete/find unit.
// Field widths, opcodes, status codes and transaction payload types.
// No dependencies.
`timescale 1ns / 1ps

package iaidf_pkg;

   localparam int OP_W       = 3;
   localparam int POS_W      = 7;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int FPOS_W     = 6;
   localparam int COUNT_W    = 7;
   localparam int CFG_W      = 7;

   localparam int DEF_MAX_DEPTH = 64;
   localparam int SCAN_GRP      = 8;

   localparam logic [CFG_W-1:0] CAP_RESET = 7'd4;

   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_EDIT   = 3'd3;
   localparam logic [OP_W-1:0] OP_READ   = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] read_value;
      logic                      found;
      logic [FPOS_W-1:0]         found_position;
      logic [COUNT_W-1:0]        element_count;
      logic [COUNT_W-1:0]        capacity_now;
   } rsp_type;

   typedef struct packed {
      logic shift_up;
      logic shift_down;
      logic load;
      logic compare;
   } cell_cmd_type;

endpackage

// ===== design/iaidf_chan_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
// Depends on iaidf_pkg.
`timescale 1ns / 1ps

interface iaidf_req_if;
   logic              valid;
   logic              ready;
   iaidf_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface iaidf_rsp_if;
   logic              valid;
   logic              ready;
   iaidf_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/iaidf_cell.sv =====
// One storage cell of the table chain: holds an entry and a match flag.
// Shifts with its neighbors on insert/delete. Depends on iaidf_pkg.
`timescale 1ns / 1ps

module iaidf_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 7
) (
   input  logic                          clock,
   input  iaidf_pkg::cell_cmd_type       cmd,
   input  logic [IW-1:0]                 sel_idx,
   input  logic [IW-1:0]                 count,
   input  logic [iaidf_pkg::VALUE_W-1:0] value,
   input  logic [iaidf_pkg::VALUE_W-1:0] left_entry,
   input  logic [iaidf_pkg::VALUE_W-1:0] right_entry,
   output logic [iaidf_pkg::VALUE_W-1:0] entry_q,
   output logic                          match_q
);
   import iaidf_pkg::*;

   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic [VALUE_W-1:0] entry_ff, entry_in;
   logic               match_ff, match_in;

   always_comb begin
      entry_in = entry_ff;
      match_in = match_ff;
      if (cmd.shift_up) begin
         if (MY_IDX > sel_idx) begin
            entry_in = left_entry;
         end else if (MY_IDX == sel_idx) begin
            entry_in = value;
         end
      end else if (cmd.shift_down) begin
         if (MY_IDX >= sel_idx) begin
            entry_in = right_entry;
         end
      end else if (cmd.load) begin
         if (MY_IDX == sel_idx) begin
            entry_in = value;
         end
      end
      if (cmd.compare) begin
         match_in = (entry_ff == value) && (MY_IDX < count);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry_q = entry_ff;
   assign match_q = match_ff;

endmodule

// ===== design/indexed_array_insert_delete_find_unit.sv =====
// Top level of the indexed array insert/delete/find unit: command register,
// count/capacity control, chain of iaidf_cell, find scan, response register.
// Depends on iaidf_pkg, iaidf_chan_if, iaidf_cell.
//
//  channel | direction | handshake     | payload
//  --------+-----------+---------------+----------------------------------------
//  req_if  | in        | valid/ready   | op, position, value
//  rsp_if  | out       | valid/ready   | status, read_value, found,
//          |           |               | found_position, element_count,
//          |           |               | capacity_now
//  csr     | in        | csr_we        | csr_wdata = initial_capacity
//
// A request lands in a command register, then executes for append, insert,
// delete, edit and read. For find, cells compare first, then match flags are
// scanned eight positions a cycle from the bottom. A new request is taken
// while the previous response waits. Synchronous reset clears count and sets
// capacity to CAP_RESET (clamped); no clearing pass. A stalled response
// holds the command register.
`timescale 1ns / 1ps

module indexed_array_insert_delete_find_unit #(
   parameter int MAX_DEPTH = iaidf_pkg::DEF_MAX_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   iaidf_req_if.sink                   req_if,
   iaidf_rsp_if.source                 rsp_if,
   input  logic                        csr_we,
   input  logic [iaidf_pkg::CFG_W-1:0] csr_wdata
);
   import iaidf_pkg::*;

   localparam int CW   = $clog2(MAX_DEPTH + 1);
   localparam int AW   = $clog2(MAX_DEPTH);
   localparam int IW   = (CW > POS_W) ? CW : POS_W;
   localparam int NGRP = (MAX_DEPTH + SCAN_GRP - 1) / SCAN_GRP;
   localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int OW   = $clog2(SCAN_GRP);

   localparam logic ST_EXEC = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   localparam logic [CW-1:0] CAP_MAX  = CW'(MAX_DEPTH);
   localparam logic [GW-1:0] GRP_LAST = GW'(NGRP - 1);

   function automatic logic [CW-1:0] clamp_cap(input logic [CFG_W-1:0] c);
      logic [IW-1:0] cx;
      cx = IW'(c);
      if (cx == '0) begin
         return CW'(1);
      end else if (cx > IW'(MAX_DEPTH)) begin
         return CAP_MAX;
      end else begin
         return CW'(cx);
      end
   endfunction

   logic               pend_valid_ff, pend_valid_in;
   req_type            pend_ff, pend_in;
   logic               state_ff, state_in;
   logic [GW-1:0]      grp_ff, grp_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      cap_ff, cap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [VALUE_W-1:0] entry_q [MAX_DEPTH];
   logic [MAX_DEPTH-1:0]      match_vec;
   logic [NGRP*SCAN_GRP-1:0]  match_pad;
   logic [SCAN_GRP-1:0]       grp_bits;
   logic [OW-1:0]             hit_off;
   logic                      hit;
   logic                      scan_done;
   logic [GW+OW-1:0]          fpos_full;

   cell_cmd_type       cmd;
   logic [IW-1:0]      sel_idx;
   logic [IW-1:0]      count_x;
   logic [IW-1:0]      pos_x;
   logic               out_free;
   logic               is_find;
   logic               exec_fire;
   logic               finish_exec;
   logic               finish_scan;
   logic               req_take;
   logic               room_ok;
   logic [CW-1:0]      grown_cap;
   logic [CW:0]        dbl_cap;
   logic [CW-1:0]      cnt_dec;
   logic [STATUS_W-1:0] ex_status;
   logic [VALUE_W-1:0] ex_rd;
   logic [CW-1:0]      ex_count;
   logic [CW-1:0]      ex_cap;
   logic               ex_cmd_up, ex_cmd_down, ex_cmd_load;

   assign count_x  = IW'(count_ff);
   assign pos_x    = IW'(pend_ff.position);
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign is_find  = (pend_ff.op == OP_FIND);

   assign room_ok = (count_ff < cap_ff) || (cap_ff < CAP_MAX);
   assign dbl_cap = {cap_ff, 1'b0};
   assign cnt_dec = count_ff - CW'(1);

   always_comb begin
      if (count_ff < cap_ff) begin
         grown_cap = cap_ff;
      end else if (dbl_cap > (CW + 1)'(MAX_DEPTH)) begin
         grown_cap = CAP_MAX;
      end else begin
         grown_cap = CW'(dbl_cap);
      end
   end

   // operation decode
   always_comb begin
      ex_status   = STATUS_OK;
      ex_rd       = '0;
      ex_count    = count_ff;
      ex_cap      = cap_ff;
      ex_cmd_up   = 1'b0;
      ex_cmd_down = 1'b0;
      ex_cmd_load = 1'b0;
      sel_idx     = pos_x;
      case (pend_ff.op)
         OP_APPEND: begin
            sel_idx = count_x;
            if (!room_ok) begin
               ex_status = STATUS_FULL;
            end else begin
               ex_cmd_load = 1'b1;
               ex_count    = count_ff + CW'(1);
               ex_cap      = grown_cap;
            end
         end
         OP_INSERT: begin
            if (pos_x > count_x) begin
               ex_status = STATUS_INVALID;
            end else if (!room_ok) begin
               ex_status = STATUS_FULL;
            end else begin
               ex_cmd_up = 1'b1;
               ex_count  = count_ff + CW'(1);
               ex_cap    = grown_cap;
            end
         end
         OP_DELETE: begin
            if (count_ff == '0) begin
               ex_status = STATUS_EMPTY;
            end else if (pos_x >= count_x) begin
               ex_status = STATUS_INVALID;
            end else begin
               ex_cmd_down = 1'b1;
               ex_count    = cnt_dec;
               if (((cap_ff >> 1) >= cnt_dec) && (cap_ff > CW'(1))) begin
                  ex_cap = cap_ff >> 1;
               end
            end
         end
         OP_EDIT: begin
            if (pos_x >= count_x) begin
               ex_status = STATUS_INVALID;
            end else begin
               ex_cmd_load = 1'b1;
            end
         end
         OP_READ: begin
            if (pos_x >= count_x) begin
               ex_status = STATUS_INVALID;
               ex_rd     = '1;
            end else begin
               ex_rd = entry_q[pos_x[AW-1:0]];
            end
         end
         default: begin
         end
      endcase
   end

   assign exec_fire   = (state_ff == ST_EXEC) && pend_valid_ff && (is_find || out_free);
   assign finish_exec = exec_fire && !is_find;
   assign finish_scan = (state_ff == ST_SCAN) && scan_done && out_free;
   assign req_if.ready = !pend_valid_ff || finish_exec || finish_scan;
   assign req_take     = req_if.valid && req_if.ready;

   assign cmd.shift_up   = finish_exec && ex_cmd_up;
   assign cmd.shift_down = finish_exec && ex_cmd_down;
   assign cmd.load       = finish_exec && ex_cmd_load;
   assign cmd.compare    = exec_fire && is_find;

   for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
      logic [VALUE_W-1:0] left_entry;
      logic [VALUE_W-1:0] right_entry;
      if (i == 0) begin : g_first
         assign left_entry = entry_q[i];
      end else begin : g_mid_l
         assign left_entry = entry_q[i-1];
      end
      if (i == MAX_DEPTH - 1) begin : g_last
         assign right_entry = entry_q[i];
      end else begin : g_mid_r
         assign right_entry = entry_q[i+1];
      end
      iaidf_cell #(
         .INDEX (i),
         .IW    (IW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .sel_idx     (sel_idx),
         .count       (count_x),
         .value       (pend_ff.value),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry_q     (entry_q[i]),
         .match_q     (match_vec[i])
      );
   end

   // find scan, one group of match flags per cycle
   assign match_pad = (NGRP * SCAN_GRP)'(match_vec);
   assign grp_bits  = match_pad[{grp_ff, OW'(0)} +: SCAN_GRP];
   assign hit       = |grp_bits;
   assign scan_done = hit || (grp_ff == GRP_LAST);
   assign fpos_full = {grp_ff, hit_off};

   always_comb begin
      hit_off = '0;
      for (int k = SCAN_GRP - 1; k >= 0; k--) begin
         if (grp_bits[k]) begin
            hit_off = OW'(k);
         end
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      state_in      = state_ff;
      grp_in        = grp_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (finish_exec || finish_scan) begin
         pend_valid_in = 1'b0;
      end
      if (req_take) begin
         pend_valid_in = 1'b1;
         pend_in       = req_if.payload;
      end

      case (state_ff)
         ST_EXEC: begin
            if (exec_fire && is_find) begin
               state_in = ST_SCAN;
               grp_in   = '0;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (out_free) begin
                  state_in = ST_EXEC;
               end
            end else begin
               grp_in = grp_ff + GW'(1);
            end
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase

      if (finish_exec) begin
         count_in                = ex_count;
         cap_in                  = ex_cap;
         rsp_valid_in            = 1'b1;
         rsp_in.status           = ex_status;
         rsp_in.read_value       = ex_rd;
         rsp_in.found            = 1'b0;
         rsp_in.found_position   = '0;
         rsp_in.element_count    = COUNT_W'(ex_count);
         rsp_in.capacity_now     = COUNT_W'(ex_cap);
      end else if (finish_scan) begin
         rsp_valid_in            = 1'b1;
         rsp_in.status           = STATUS_OK;
         rsp_in.read_value       = '0;
         rsp_in.found            = hit;
         rsp_in.found_position   = hit ? FPOS_W'(fpos_full) : '0;
         rsp_in.element_count    = COUNT_W'(count_ff);
         rsp_in.capacity_now     = COUNT_W'(cap_ff);
      end else if (csr_we) begin
         if (count_ff == '0) begin
            cap_in = clamp_cap(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         state_ff      <= ST_EXEC;
         grp_ff        <= '0;
         count_ff      <= '0;
         cap_ff        <= clamp_cap(CAP_RESET);
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         state_ff      <= state_in;
         grp_ff        <= grp_in;
         count_ff      <= count_in;
         cap_ff        <= cap_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

endmodule

// ===== dv/indexed_array_insert_delete_find_unit_test.sv =====
// Self-checking testbench for the indexed array insert/delete/find unit.
// Drives directed and random table operations across capacity settings and
// checks every response against a shadow table. Needs iaidf_pkg, iaidf_chan_if.
`timescale 1ns / 1ps

module indexed_array_insert_delete_find_unit_test;
   import iaidf_pkg::*;

   localparam int DEPTH         = DEF_MAX_DEPTH;
   localparam int POS_MAX       = (1 << POS_W) - 1;
   localparam int GAP_MAX       = 12;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_MAX    = 10;

   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             csr_we    = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   iaidf_req_if req_if();
   iaidf_rsp_if rsp_if();

   indexed_array_insert_delete_find_unit #(
      .MAX_DEPTH (DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the table and its capacity
   logic signed [VALUE_W-1:0] shadow_entries [DEPTH];
   int                        shadow_count;
   int                        shadow_cap;

   req_type req_backlog [$];
   rsp_type results_due [$];

   logic    req_fire, rsp_fire;
   int      req_gap, rsp_wait, hold_left;
   bit      hold_armed, hold_taken, quiet_gaps;
   logic    next_ready;
   rsp_type got_rsp, want_rsp;

   int cycle_count, error_count, checked_count, accepted_count, cfg_writes;
   int peak_fill, find_hits;
   int status_seen [4];

   function automatic int bound_capacity(int c);
      if (c < 1) return 1;
      if (c > DEPTH) return DEPTH;
      return c;
   endfunction

   function automatic bit grow_for_write();
      if (shadow_count < shadow_cap) return 1'b1;
      if (shadow_cap >= DEPTH) return 1'b0;
      shadow_cap = bound_capacity(shadow_cap * 2);
      return shadow_count < shadow_cap;
   endfunction

   function automatic rsp_type apply_table_op(req_type r);
      rsp_type o;
      int      pos;
      o   = '0;
      pos = r.position;
      case (r.op)
         OP_APPEND: begin
            if (!grow_for_write()) begin
               o.status = STATUS_FULL;
            end else begin
               shadow_entries[shadow_count] = r.value;
               shadow_count++;
            end
         end
         OP_INSERT: begin
            if (pos > shadow_count) begin
               o.status = STATUS_INVALID;
            end else if (!grow_for_write()) begin
               o.status = STATUS_FULL;
            end else begin
               for (int i = shadow_count; i > pos; i--)
                  shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[pos] = r.value;
               shadow_count++;
            end
         end
         OP_DELETE: begin
            if (shadow_count == 0) begin
               o.status = STATUS_EMPTY;
            end else if (pos >= shadow_count) begin
               o.status = STATUS_INVALID;
            end else begin
               for (int i = pos; i + 1 < shadow_count; i++)
                  shadow_entries[i] = shadow_entries[i+1];
               shadow_count--;
               if (shadow_cap / 2 >= shadow_count && shadow_cap > 1)
                  shadow_cap = shadow_cap / 2;
            end
         end
         OP_EDIT: begin
            if (pos >= shadow_count) o.status = STATUS_INVALID;
            else shadow_entries[pos] = r.value;
         end
         OP_READ: begin
            if (pos >= shadow_count) begin
               o.status     = STATUS_INVALID;
               o.read_value = -1;
            end else begin
               o.read_value = shadow_entries[pos];
            end
         end
         OP_FIND: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (!o.found && shadow_entries[i] == r.value) begin
                  o.found          = 1'b1;
                  o.found_position = FPOS_W'(i);
               end
            end
         end
         default: ;
      endcase
      o.element_count = COUNT_W'(shadow_count);
      o.capacity_now  = COUNT_W'(shadow_cap);
      return o;
   endfunction

   function automatic string rsp_text(rsp_type r);
      return $sformatf("st=%0d rd=%0d found=%0d fpos=%0d count=%0d cap=%0d",
                       r.status, r.read_value, r.found, r.found_position,
                       r.element_count, r.capacity_now);
   endfunction

   function automatic int draw_gap();
      return quiet_gaps ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_fire) req_gap = draw_gap();
         if (req_if.valid && !req_fire) begin
            // still offering, hold payload
         end else if (req_gap > 0) begin
            req_gap--;
            req_if.valid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            req_if.payload <= req_backlog.pop_front();
            req_if.valid   <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (rsp_fire) rsp_wait = draw_gap();
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_if.ready <= next_ready;
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, results_due.size());
         $display("Regression FAIL");
         $finish;
      end else if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_if.valid && req_if.ready;
         rsp_fire <= rsp_if.valid && rsp_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            got_rsp = rsp_if.payload;
            if (results_due.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("Unexpected response at cycle %0d: %s",
                           cycle_count, rsp_text(got_rsp));
            end else begin
               want_rsp = results_due.pop_front();
               checked_count++;
               if (got_rsp.status !== want_rsp.status ||
                   got_rsp.read_value !== want_rsp.read_value ||
                   got_rsp.found !== want_rsp.found ||
                   got_rsp.found_position !== want_rsp.found_position ||
                   got_rsp.element_count !== want_rsp.element_count ||
                   got_rsp.capacity_now !== want_rsp.capacity_now) begin
                  error_count++;
                  if (error_count <= REPORT_MAX) begin
                     $display("Mismatch on response %0d at cycle %0d",
                              checked_count, cycle_count);
                     $display("  expected %s", rsp_text(want_rsp));
                     $display("  actual   %s", rsp_text(got_rsp));
                  end
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            want_rsp = apply_table_op(req_if.payload);
            accepted_count++;
            status_seen[want_rsp.status]++;
            if (want_rsp.found) find_hits++;
            if (want_rsp.element_count > peak_fill) peak_fill = want_rsp.element_count;
            results_due.push_back(want_rsp);
         end
      end
   end

   task automatic wait_backlog_room();
      while (req_backlog.size() > 2) begin
         @(posedge clock);
         #2;
      end
   endtask

   task automatic offer(logic [OP_W-1:0] op, int pos, logic signed [VALUE_W-1:0] val);
      req_type r;
      wait_backlog_room();
      r.op       = op;
      r.position = POS_W'(pos);
      r.value    = val;
      req_backlog.push_back(r);
   endtask

   task automatic offer_random(mix_type mix);
      int                        w, a_lim, i_lim, d_lim, cnt, pos, sel;
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] val;
      wait_backlog_room();
      cnt = shadow_count;
      case (mix)
         MIX_GROW:     begin a_lim = 40; i_lim = 75; d_lim = 85; end
         MIX_SHRINK:   begin a_lim = 12; i_lim = 24; d_lim = 70; end
         default:      begin a_lim = 22; i_lim = 44; d_lim = 66; end
      endcase
      w = $urandom_range(0, 99);
      if (w < a_lim) op = OP_APPEND;
      else if (w < i_lim) op = OP_INSERT;
      else if (w < d_lim) op = OP_DELETE;
      else if (w < 98) begin
         case ($urandom_range(0, 2))
            0:       op = OP_EDIT;
            1:       op = OP_READ;
            default: op = OP_FIND;
         endcase
      end else begin
         op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      end

      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         if (op == OP_INSERT) pos = $urandom_range(0, cnt);
         else pos = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);
      end else if (sel < 90) begin
         pos = cnt - 1 + int'($urandom_range(0, 2));
      end else begin
         pos = $urandom_range(0, POS_MAX);
      end
      if (pos < 0) pos = 0;
      if (pos > POS_MAX) pos = POS_MAX;

      sel = $urandom_range(0, 99);
      if (op == OP_FIND && cnt > 0 && sel < 60) begin
         val = shadow_entries[$urandom_range(0, cnt - 1)];
      end else if (sel < 75) begin
         val = $urandom;
      end else if (sel < 90) begin
         val = int'($urandom_range(0, 7)) - 3;
      end else begin
         case ($urandom_range(0, 3))
            0:       val = 32'sh7FFFFFFF;
            1:       val = 32'sh80000000;
            2:       val = -1;
            default: val = 0;
         endcase
      end
      offer(op, pos, val);
   endtask

   task automatic settle();
      while (req_backlog.size() != 0 || req_if.valid || results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CFG_W-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      if (shadow_count == 0) shadow_cap = bound_capacity(v);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_writes++;
   endtask

   task automatic empty_table();
      int n;
      settle();
      n = shadow_count;
      for (int i = 0; i < n; i++)
         offer(OP_DELETE, $urandom_range(0, n - 1 - i), $urandom);
   endtask

   task automatic run_phase(bit drain, logic [CFG_W-1:0] cap_cfg, mix_type mix,
                            bit quiet, bit hold, int n);
      if (drain) empty_table();
      settle();
      write_capacity(cap_cfg);
      quiet_gaps = quiet;
      if (hold) hold_armed = 1'b1;
      for (int k = 0; k < n; k++) offer_random(mix);
   endtask

   initial begin
      req_if.valid    = 1'b0;
      req_if.payload  = '0;
      rsp_if.ready    = 1'b0;
      shadow_count    = 0;
      shadow_cap      = bound_capacity(CAP_RESET);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table corner cases, growth, boundaries, first match, spare opcodes
      offer(OP_READ,   0,       0);
      offer(OP_EDIT,   0,       1);
      offer(OP_DELETE, 0,       0);
      offer(OP_FIND,   0,       0);
      offer(OP_INSERT, 1,       2);
      offer(OP_INSERT, 0,       32'sh7FFFFFFF);
      offer(OP_APPEND, 0,       32'sh80000000);
      offer(OP_APPEND, 0,       0);
      offer(OP_APPEND, 0,       -1);
      offer(OP_APPEND, 0,       5);
      offer(OP_INSERT, 5,       0);
      offer(OP_FIND,   0,       -1);
      offer(OP_FIND,   0,       0);
      offer(OP_FIND,   0,       12345);
      offer(OP_READ,   POS_MAX, 0);
      offer(OP_EDIT,   5,       32'sh55555555);
      offer(OP_READ,   5,       0);
      offer(OP_INSERT, POS_MAX, 7);
      offer(OP_DELETE, 6,       0);
      offer(OP_DELETE, 0,       0);
      offer(OP_DELETE, 4,       0);
      offer(OP_SPARE_6, POS_MAX, -1);
      offer(OP_SPARE_7, POS_MAX, -1);
      offer(OP_READ,   0,       0);
      offer(OP_FIND,   0,       32'sh80000000);

      settle();
      write_capacity(7'd7);

      run_phase(1'b1, 7'd1,   MIX_GROW,     1'b0, 1'b1, 150);
      run_phase(1'b0, 7'd127, MIX_BALANCED, 1'b0, 1'b0, 150);
      run_phase(1'b1, 7'd64,  MIX_GROW,     1'b1, 1'b0, 150);
      run_phase(1'b0, 7'd0,   MIX_SHRINK,   1'b0, 1'b0, 120);
      run_phase(1'b1, 7'd0,   MIX_BALANCED, 1'b1, 1'b0, 150);
      run_phase(1'b1, 7'd127, MIX_GROW,     1'b0, 1'b0, 150);
      run_phase(1'b0, CFG_W'($urandom_range(1, DEPTH)), MIX_SHRINK,   1'b0, 1'b0, 130);
      run_phase(1'b1, CFG_W'($urandom_range(1, DEPTH)), MIX_BALANCED, 1'b0, 1'b0, 200);

      settle();
      if (results_due.size() != 0) begin
         error_count += results_due.size();
         $display("%0d expected responses never arrived", results_due.size());
      end
      $display("Covered %0d transactions over %0d capacity writes, %0d checked, peak fill %0d/%0d",
               accepted_count, cfg_writes, checked_count, peak_fill, DEPTH);
      $display("Status ok/invalid/empty/full: %0d/%0d/%0d/%0d, find hits %0d, errors %0d",
               status_seen[STATUS_OK], status_seen[STATUS_INVALID],
               status_seen[STATUS_EMPTY], status_seen[STATUS_FULL],
               find_hits, error_count);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
